[hdl/spa_pkg.sv]
// ----------------------------------------------------------------------------
// spa_pkg
// Payload types, fixed widths and the square-root seed table for the
// spectrum power averager.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POWER_W  = 32;
  localparam int COUNT_W  = 8;
  localparam int MAG_W    = 16;
  localparam int BIN_W    = 7;
  localparam logic [MAG_W-1:0] MAG_MAX = 16'hFFFF;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] bin_real;
    logic signed [SAMPLE_W-1:0] bin_imag;
  } in_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [BIN_W-1:0] bin_number;
    logic             frame_done;
  } out_t;

  // seed for the root, indexed by leading-zero count of the sum
  function automatic logic [MAG_W-1:0] guess_by_lz(input logic [4:0] idx);
    logic [MAG_W-1:0] g;
    case (idx)
      5'd0:  g = 16'd55109;
      5'd1:  g = 16'd38968;
      5'd2:  g = 16'd27555;
      5'd3:  g = 16'd19484;
      5'd4:  g = 16'd13778;
      5'd5:  g = 16'd9742;
      5'd6:  g = 16'd6889;
      5'd7:  g = 16'd4871;
      5'd8:  g = 16'd3445;
      5'd9:  g = 16'd2436;
      5'd10: g = 16'd1723;
      5'd11: g = 16'd1218;
      5'd12: g = 16'd862;
      5'd13: g = 16'd609;
      5'd14: g = 16'd431;
      5'd15: g = 16'd305;
      5'd16: g = 16'd216;
      5'd17: g = 16'd153;
      5'd18: g = 16'd108;
      5'd19: g = 16'd77;
      5'd20: g = 16'd54;
      5'd21: g = 16'd39;
      5'd22: g = 16'd27;
      5'd23: g = 16'd20;
      5'd24: g = 16'd14;
      5'd25: g = 16'd10;
      5'd26: g = 16'd7;
      5'd27: g = 16'd5;
      5'd28: g = 16'd4;
      5'd29: g = 16'd3;
      5'd30: g = 16'd2;
      5'd31: g = 16'd1;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

[hdl/spa_ram.sv]
// ----------------------------------------------------------------------------
// spa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module spa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/spa_div.sv]
// ----------------------------------------------------------------------------
// spa_div
// Pipelined restoring divider, 32-bit dividend, one quotient bit per stage,
// with a sideband that travels alongside.
// ----------------------------------------------------------------------------
module spa_div #(
  parameter int DW     = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       dividend,
  input  logic [DW-1:0]     divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       quotient,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STAGES = 32;

  logic              vld_r  [STAGES];
  logic [DW-1:0]     rem_r  [STAGES];
  logic [31:0]       dvd_r  [STAGES];
  logic [31:0]       quo_r  [STAGES];
  logic [DW-1:0]     dsr_r  [STAGES];
  logic [SIDE_W-1:0] side_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic              pv;
    logic [DW-1:0]     prem;
    logic [DW-1:0]     pdsr;
    logic [31:0]       pdvd;
    logic [31:0]       pquo;
    logic [SIDE_W-1:0] pside;
    logic [DW:0]       trial;
    logic [DW:0]       diff;
    logic              take;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign pdvd  = dividend;
      assign pquo  = '0;
      assign pdsr  = divisor;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld_r[i-1];
      assign prem  = rem_r[i-1];
      assign pdvd  = dvd_r[i-1];
      assign pquo  = quo_r[i-1];
      assign pdsr  = dsr_r[i-1];
      assign pside = side_r[i-1];
    end

    assign trial = {prem, pdvd[31]};
    assign diff  = trial - {1'b0, pdsr};
    assign take  = (trial >= {1'b0, pdsr});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= take ? diff[DW-1:0] : trial[DW-1:0];
        dvd_r[i]  <= {pdvd[30:0], 1'b0};
        quo_r[i]  <= {pquo[30:0], take};
        dsr_r[i]  <= pdsr;
        side_r[i] <= pside;
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign quotient  = quo_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

[hdl/spa_root.sv]
// ----------------------------------------------------------------------------
// spa_root
// Approximate square root: table seed from the leading-zero count, then two
// pipelined Newton steps, saturated to 16 bits. A zero input gives zero.
// ----------------------------------------------------------------------------
module spa_root #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       value,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [15:0]       root,
  output logic [SIDE_W-1:0] out_side
);
  import spa_pkg::*;

  localparam int S1_W = 32 + MAG_W + 1 + SIDE_W;
  localparam int S2_W = 32 + 1 + SIDE_W;

  function automatic logic [5:0] lead_zeros(input logic [31:0] v);
    logic [5:0] z;
    z = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        z = 6'(31 - i);
      end
    end
    return z;
  endfunction

  logic              a_vld_r;
  logic [31:0]       a_val_r;
  logic [MAG_W-1:0]  a_guess_r;
  logic              a_zero_r;
  logic [SIDE_W-1:0] a_side_r;
  logic [5:0]        lz;

  assign lz = lead_zeros(value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_val_r   <= value;
      a_guess_r <= guess_by_lz(lz[4:0]);
      a_zero_r  <= (value == '0);
      a_side_r  <= in_side;
    end
  end

  // first newton step: v / g
  logic              d1_vld;
  logic [31:0]       d1_quo;
  logic [S1_W-1:0]   d1_side;

  spa_div #(.DW(MAG_W), .SIDE_W(S1_W)) u_div1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_vld_r),
    .dividend  (a_val_r),
    .divisor   (a_guess_r),
    .in_side   ({a_val_r, a_guess_r, a_zero_r, a_side_r}),
    .out_valid (d1_vld),
    .quotient  (d1_quo),
    .out_side  (d1_side)
  );

  logic [31:0]       d1_val;
  logic [MAG_W-1:0]  d1_guess;
  logic              d1_zero;
  logic [SIDE_W-1:0] d1_sd;
  logic [32:0]       g1_sum;

  assign {d1_val, d1_guess, d1_zero, d1_sd} = d1_side;
  assign g1_sum = {1'b0, d1_quo} + {17'b0, d1_guess};

  logic              b_vld_r;
  logic [31:0]       b_val_r;
  logic [31:0]       b_g1_r;
  logic              b_zero_r;
  logic [SIDE_W-1:0] b_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_val_r  <= d1_val;
      b_g1_r   <= g1_sum[32:1];
      b_zero_r <= d1_zero;
      b_side_r <= d1_sd;
    end
  end

  // second newton step: v / g1
  logic              d2_vld;
  logic [31:0]       d2_quo;
  logic [S2_W-1:0]   d2_side;

  spa_div #(.DW(32), .SIDE_W(S2_W)) u_div2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_vld_r),
    .dividend  (b_val_r),
    .divisor   (b_g1_r),
    .in_side   ({b_g1_r, b_zero_r, b_side_r}),
    .out_valid (d2_vld),
    .quotient  (d2_quo),
    .out_side  (d2_side)
  );

  logic [31:0]       d2_g1;
  logic              d2_zero;
  logic [SIDE_W-1:0] d2_sd;
  logic [32:0]       g2_sum;
  logic [31:0]       g2;
  logic [15:0]       mag_nxt;

  assign {d2_g1, d2_zero, d2_sd} = d2_side;
  assign g2_sum = {1'b0, d2_quo} + {1'b0, d2_g1};
  assign g2     = g2_sum[32:1];

  always_comb begin
    if (d2_zero) begin
      mag_nxt = '0;
    end else if (g2 > 32'(MAG_MAX)) begin
      mag_nxt = MAG_MAX;
    end else begin
      mag_nxt = g2[15:0];
    end
  end

  logic              c_vld_r;
  logic [15:0]       c_mag_r;
  logic [SIDE_W-1:0] c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_mag_r  <= mag_nxt;
      c_side_r <= d2_sd;
    end
  end

  assign out_valid = c_vld_r;
  assign root      = c_mag_r;
  assign out_side  = c_side_r;

endmodule

[hdl/spectrum_power_averager.sv]
// ----------------------------------------------------------------------------
// spectrum_power_averager
// Averaged power spectrum: per-bin re^2+im^2 divided by the average count,
// accumulated over a period, then an approximate square root per bin.
// ----------------------------------------------------------------------------
// pipeline: input register, squares, power sum, then the three 32-stage
//   bit-per-stage dividers (average, two newton steps) with the accumulate
//   stage and the root's seed, step and output registers between them
// throughput: one bin per cycle; the whole pipe advances when the output
//   register is empty or taken
// reset: bin position and frame counter clear, average count returns to 1;
//   the sum memory is not cleared since every period begins by overwriting
module spectrum_power_averager #(
  parameter int BIN_COUNT = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  spa_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output spa_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_data
);
  import spa_pkg::*;

  localparam int POS_W = $clog2(BIN_COUNT);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BIN_COUNT - 1);
  // tag: pos, overwrite, last frame, end of frame
  localparam int TAG_W = POS_W + 3;

  logic en;
  logic accept;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;

  // configuration
  logic [COUNT_W-1:0] avg_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      avg_r <= cfg_data;
    end
  end

  // frame tracking
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [COUNT_W-1:0] fc_r, fc_nxt;
  logic               last_r, last_nxt;
  logic [COUNT_W-1:0] div_val;
  logic               eof;

  assign div_val = (avg_r == '0) ? COUNT_W'(1) : avg_r;
  assign eof     = (pos_r == LAST_POS);

  always_comb begin
    last_nxt = last_r;
    if (pos_r == '0) begin
      last_nxt = ({1'b0, fc_r} + 9'd1) >= {1'b0, div_val};
    end
    pos_nxt = pos_r + POS_W'(1);
    fc_nxt  = fc_r;
    if (eof) begin
      pos_nxt = '0;
      fc_nxt  = last_nxt ? '0 : fc_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fc_r   <= '0;
      last_r <= 1'b0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      fc_r   <= fc_nxt;
      last_r <= last_nxt;
    end
  end

  // stage 0: input register
  logic                       s0_vld_r;
  logic signed [SAMPLE_W-1:0] s0_re_r, s0_im_r;
  logic [COUNT_W-1:0]         s0_div_r;
  logic [TAG_W-1:0]           s0_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_re_r  <= in_data.bin_real;
      s0_im_r  <= in_data.bin_imag;
      s0_div_r <= div_val;
      s0_tag_r <= {pos_r, (fc_r == '0), last_nxt, eof};
    end
  end

  // stage 1: squares
  logic                      s1_vld_r;
  logic signed [POWER_W-1:0] s1_rr_r, s1_ii_r;
  logic [COUNT_W-1:0]        s1_div_r;
  logic [TAG_W-1:0]          s1_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rr_r  <= POWER_W'(s0_re_r) * POWER_W'(s0_re_r);
      s1_ii_r  <= POWER_W'(s0_im_r) * POWER_W'(s0_im_r);
      s1_div_r <= s0_div_r;
      s1_tag_r <= s0_tag_r;
    end
  end

  // stage 2: power sum, fits 32 bits exactly
  logic               s2_vld_r;
  logic [POWER_W-1:0] s2_pwr_r;
  logic [COUNT_W-1:0] s2_div_r;
  logic [TAG_W-1:0]   s2_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pwr_r <= unsigned'(s1_rr_r) + unsigned'(s1_ii_r);
      s2_div_r <= s1_div_r;
      s2_tag_r <= s1_tag_r;
    end
  end

  // share = power / average count
  logic               dv_vld;
  logic [POWER_W-1:0] dv_share;
  logic [TAG_W-1:0]   dv_tag;

  spa_div #(.DW(COUNT_W), .SIDE_W(TAG_W)) u_avg_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_vld_r),
    .dividend  (s2_pwr_r),
    .divisor   (s2_div_r),
    .in_side   (s2_tag_r),
    .out_valid (dv_vld),
    .quotient  (dv_share),
    .out_side  (dv_tag)
  );

  // accumulate: read sum as the transaction enters, write back one stage later
  logic               acc_vld_r;
  logic [POWER_W-1:0] acc_share_r;
  logic [TAG_W-1:0]   acc_tag_r;
  logic [POWER_W-1:0] ram_rd;
  logic [POWER_W-1:0] acc_sum;
  logic [POWER_W:0]   acc_add;
  logic [POS_W-1:0]   acc_pos;
  logic               acc_ovw, acc_last, acc_eof;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
    end else if (en) begin
      acc_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_share_r <= dv_share;
      acc_tag_r   <= dv_tag;
    end
  end

  assign {acc_pos, acc_ovw, acc_last, acc_eof} = acc_tag_r;
  assign acc_add = {1'b0, ram_rd} + {1'b0, acc_share_r};

  always_comb begin
    if (acc_ovw) begin
      acc_sum = acc_share_r;
    end else if (acc_add[POWER_W]) begin
      acc_sum = '1;
    end else begin
      acc_sum = acc_add[POWER_W-1:0];
    end
  end

  spa_ram #(.WIDTH(POWER_W), .DEPTH(BIN_COUNT)) u_sums (
    .clk     (clk),
    .rd_en   (en),
    .rd_addr (dv_tag[TAG_W-1:3]),
    .rd_data (ram_rd),
    .wr_en   (en && acc_vld_r),
    .wr_addr (acc_pos),
    .wr_data (acc_sum)
  );

  // magnitude
  logic [POS_W+BIN_W-1:0] pos_ext;
  logic [BIN_W:0]         rt_side;
  logic                   rt_vld;
  logic [MAG_W-1:0]       rt_mag;

  assign pos_ext = (POS_W + BIN_W)'(acc_pos);

  spa_root #(.SIDE_W(BIN_W + 1)) u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (acc_vld_r && acc_last),
    .value     (acc_sum),
    .in_side   ({pos_ext[BIN_W-1:0], acc_eof}),
    .out_valid (rt_vld),
    .root      (rt_mag),
    .out_side  (rt_side)
  );

  assign out_valid           = rt_vld;
  assign out_data.magnitude  = rt_mag;
  assign out_data.bin_number = rt_side[BIN_W:1];
  assign out_data.frame_done = rt_side[0];

endmodule
